// ----- rtl/core/rmr_pkg.sv -----
package rmr_pkg;

    // Fixed field widths.
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = 32;
    localparam int AREA_W  = 2 * DIM_W;
    localparam int CNT_W   = $clog2(SUM_W);
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Largest frame dimension; also the reset value of the frame row count.
    localparam int MAX_DIM = 4096;

    // Register indexes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_RECT_LEFT   = 3'd0,
        REG_RECT_TOP    = 3'd1,
        REG_RECT_WIDTH  = 3'd2,
        REG_RECT_HEIGHT = 3'd3,
        REG_FRAME_ROWS  = 3'd4,
        REG_FLIP_ROWS   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] rect_left;
        logic [COORD_W-1:0] rect_top;
        logic [DIM_W-1:0]   rect_width;
        logic [DIM_W-1:0]   rect_height;
        logic [DIM_W-1:0]   frame_rows;
        logic               flip_rows;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DIV  = 2'd1,
        ST_POST = 2'd2
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc;
        logic start;
        logic step;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
    } t_status;

endpackage

// ----- rtl/core/region_mean_rgb.sv -----
// Pixels are taken at one per cycle while the block is collecting a frame.
// The transfer that carries tlast starts a restoring division (one
// quotient bit per cycle in each color lane); no pixel is taken while the
// division runs, nor later while the previous result still waits. Reset
// (synchronous, active low) clears the sums, the handshake state and the
// registers; frame rows is 4096.
module region_mean_rgb (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // APB-style configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rmr_pkg::ADDR_W-1:0] paddr,
    input  logic [rmr_pkg::DATA_W-1:0] pwdata,
    output logic [rmr_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    // Pixel stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata: pixel_col[11:0], pixel_row[23:12], blue_byte[31:24],
    //        green_byte[39:32], red_byte[47:40]
    input  logic [47:0]               s_axis_tdata,
    // tlast: frame_end
    input  logic                      s_axis_tlast,
    // Result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata: mean_red[7:0], mean_green[15:8], mean_blue[23:16]
    output logic [23:0]               m_axis_tdata,
    // tuser: empty_region
    output logic                      m_axis_tuser
);
    import rmr_pkg::*;

    t_cfg              w_cfg;
    t_cmd              w_cmd;
    t_status           w_status;
    logic [CHAN_W-1:0] w_mean_red;
    logic [CHAN_W-1:0] w_mean_green;
    logic [CHAN_W-1:0] w_mean_blue;

    rmr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rmr_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_pixel_col    (s_axis_tdata[11:0]),
        .i_pixel_row    (s_axis_tdata[23:12]),
        .i_blue_byte    (s_axis_tdata[31:24]),
        .i_green_byte   (s_axis_tdata[39:32]),
        .i_red_byte     (s_axis_tdata[47:40]),
        .o_mean_red     (w_mean_red),
        .o_mean_green   (w_mean_green),
        .o_mean_blue    (w_mean_blue),
        .o_empty_region (m_axis_tuser)
    );

    assign m_axis_tdata = {w_mean_blue, w_mean_green, w_mean_red};

endmodule

// ----- rtl/core/rmr_regs.sv -----
module rmr_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rmr_pkg::ADDR_W-1:0] paddr,
    input  logic [rmr_pkg::DATA_W-1:0] pwdata,
    output logic [rmr_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output rmr_pkg::t_cfg             o_cfg
);
    import rmr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes on the access cycle of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rect_left   <= '0;
            r_cfg.rect_top    <= '0;
            r_cfg.rect_width  <= '0;
            r_cfg.rect_height <= '0;
            r_cfg.frame_rows  <= DIM_W'(MAX_DIM);
            r_cfg.flip_rows   <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_RECT_LEFT:   r_cfg.rect_left   <= pwdata[COORD_W-1:0];
                REG_RECT_TOP:    r_cfg.rect_top    <= pwdata[COORD_W-1:0];
                REG_RECT_WIDTH:  r_cfg.rect_width  <= pwdata[DIM_W-1:0];
                REG_RECT_HEIGHT: r_cfg.rect_height <= pwdata[DIM_W-1:0];
                REG_FRAME_ROWS:  r_cfg.frame_rows  <= pwdata[DIM_W-1:0];
                REG_FLIP_ROWS:   r_cfg.flip_rows   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (w_idx)
            REG_RECT_LEFT:   prdata = DATA_W'(r_cfg.rect_left);
            REG_RECT_TOP:    prdata = DATA_W'(r_cfg.rect_top);
            REG_RECT_WIDTH:  prdata = DATA_W'(r_cfg.rect_width);
            REG_RECT_HEIGHT: prdata = DATA_W'(r_cfg.rect_height);
            REG_FRAME_ROWS:  prdata = DATA_W'(r_cfg.frame_rows);
            REG_FLIP_ROWS:   prdata = DATA_W'(r_cfg.flip_rows);
            default:         prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/rmr_ctrl.sv -----
module rmr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rmr_pkg::t_status  i_status,
    output rmr_pkg::t_cmd     o_cmd
);
    import rmr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        n_out_valid  = r_out_valid & ~i_out_ready;
        case (r_state)
            ST_RUN: begin
                o_in_ready = 1'b1;
                o_cmd.acc  = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                // Wait until the output register is free or being emptied.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/rmr_datapath.sv -----
module rmr_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rmr_pkg::t_cfg               i_cfg,
    input  rmr_pkg::t_cmd               i_cmd,
    output rmr_pkg::t_status            o_status,
    input  logic [rmr_pkg::COORD_W-1:0] i_pixel_col,
    input  logic [rmr_pkg::COORD_W-1:0] i_pixel_row,
    input  logic [rmr_pkg::CHAN_W-1:0]  i_blue_byte,
    input  logic [rmr_pkg::CHAN_W-1:0]  i_green_byte,
    input  logic [rmr_pkg::CHAN_W-1:0]  i_red_byte,
    output logic [rmr_pkg::CHAN_W-1:0]  o_mean_red,
    output logic [rmr_pkg::CHAN_W-1:0]  o_mean_green,
    output logic [rmr_pkg::CHAN_W-1:0]  o_mean_blue,
    output logic                        o_empty_region
);
    import rmr_pkg::*;

    localparam int LANES = 3;
    localparam int ROW_W = DIM_W + 2;

    // One restoring division step: returns {remainder, shifted dividend with quotient bit}.
    function automatic logic [AREA_W+SUM_W-1:0] f_div_step(
        input logic [AREA_W-1:0] rem,
        input logic [SUM_W-1:0]  dvd,
        input logic [AREA_W-1:0] area
    );
        logic [AREA_W:0] sh;
        logic [AREA_W:0] diff;
        sh   = {rem, dvd[SUM_W-1]};
        diff = sh - {1'b0, area};
        if (diff[AREA_W]) begin
            f_div_step = {sh[AREA_W-1:0], dvd[SUM_W-2:0], 1'b0};
        end else begin
            f_div_step = {diff[AREA_W-1:0], dvd[SUM_W-2:0], 1'b1};
        end
    endfunction

    logic [SUM_W-1:0]  r_sum   [LANES];
    logic [SUM_W-1:0]  w_sum_n [LANES];
    logic [SUM_W-1:0]  r_dvd   [LANES];
    logic [AREA_W-1:0] r_rem   [LANES];
    logic [CHAN_W-1:0] w_byte  [LANES];
    logic [AREA_W-1:0] r_area;
    logic [CNT_W-1:0]  r_cnt;
    logic [CHAN_W-1:0] r_mean  [LANES];
    logic              r_empty;

    logic              w_col_hit;
    logic              w_row_hit;
    logic              w_hit;
    logic [DIM_W:0]    w_col_end;
    logic [DIM_W:0]    w_row_end;
    logic [ROW_W-1:0]  w_k;

    // Column test.
    assign w_col_end = {2'b0, i_cfg.rect_left} + {1'b0, i_cfg.rect_width};
    assign w_col_hit = (i_pixel_col >= i_cfg.rect_left)
                     && ({2'b0, i_pixel_col} < w_col_end);

    // Row test, direct or flipped. The flipped offset is a signed value.
    assign w_row_end = {2'b0, i_cfg.rect_top} + {1'b0, i_cfg.rect_height};
    assign w_k = {2'b0, i_cfg.frame_rows} - ROW_W'(1)
               - {3'b0, i_cfg.rect_top} - {3'b0, i_pixel_row};
    always_comb begin
        if (i_cfg.flip_rows) begin
            w_row_hit = !w_k[ROW_W-1] && (w_k[ROW_W-2:0] < {1'b0, i_cfg.rect_height});
        end else begin
            w_row_hit = (i_pixel_row >= i_cfg.rect_top)
                      && ({2'b0, i_pixel_row} < w_row_end);
        end
    end
    assign w_hit = w_col_hit & w_row_hit;

    assign w_byte[0] = i_red_byte;
    assign w_byte[1] = i_green_byte;
    assign w_byte[2] = i_blue_byte;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_sum_n[i] = r_sum[i] + (w_hit ? SUM_W'(w_byte[i]) : SUM_W'(0));
        end
    end

    // Running sums; cleared once the frame's totals move to the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_sum[i] <= '0;
            end
        end else if (i_cmd.acc) begin
            for (int i = 0; i < LANES; i++) begin
                r_sum[i] <= i_cmd.start ? SUM_W'(0) : w_sum_n[i];
            end
        end
    end

    // Step counter of the division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.start) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end
    assign o_status.div_last = (r_cnt == {CNT_W{1'b1}});

    // Three restoring dividers, one quotient bit per cycle each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_area <= AREA_W'(i_cfg.rect_width) * AREA_W'(i_cfg.rect_height);
            for (int i = 0; i < LANES; i++) begin
                r_dvd[i] <= w_sum_n[i];
                r_rem[i] <= '0;
            end
        end else if (i_cmd.step) begin
            for (int i = 0; i < LANES; i++) begin
                {r_rem[i], r_dvd[i]} <= f_div_step(r_rem[i], r_dvd[i], r_area);
            end
        end
    end

    // Output register: saturate the quotients, force zeros for an empty area.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_empty <= (r_area == '0);
            for (int i = 0; i < LANES; i++) begin
                if (r_area == '0) begin
                    r_mean[i] <= '0;
                end else if (r_dvd[i][SUM_W-1:CHAN_W] != '0) begin
                    r_mean[i] <= {CHAN_W{1'b1}};
                end else begin
                    r_mean[i] <= r_dvd[i][CHAN_W-1:0];
                end
            end
        end
    end

    assign o_mean_red     = r_mean[0];
    assign o_mean_green   = r_mean[1];
    assign o_mean_blue    = r_mean[2];
    assign o_empty_region = r_empty;

endmodule

// ----- tb/sv/tb_region_mean_rgb.sv -----
`timescale 1ns / 1ps

module tb_region_mean_rgb;

    localparam int RANDOM_ITEMS   = 1550;
    // Time for the division after the last pixel; allow some margin.
    localparam int RESULT_LATENCY = 40;
    localparam int IDLE_PERCENT   = 17;

    // One expected result: the three channel means and the empty flag.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       empty;
    } t_mean_result;

    // Tracks the running channel sums and the rectangle settings, and holds
    // the means that the block still has to deliver.
    class mean_tracker;
        rmr_pkg::t_cfg cfg;
        bit [31:0]     red_sum;
        bit [31:0]     green_sum;
        bit [31:0]     blue_sum;
        t_mean_result  pending_means[$];
        int            mismatches;

        function new();
            cfg            = '0;
            cfg.frame_rows = 13'(rmr_pkg::MAX_DIM);
            red_sum        = '0;
            green_sum      = '0;
            blue_sum       = '0;
            mismatches     = 0;
        endfunction

        function void set_reg(rmr_pkg::t_reg_idx idx, logic [31:0] value);
            case (idx)
                rmr_pkg::REG_RECT_LEFT:   cfg.rect_left   = value[11:0];
                rmr_pkg::REG_RECT_TOP:    cfg.rect_top    = value[11:0];
                rmr_pkg::REG_RECT_WIDTH:  cfg.rect_width  = value[12:0];
                rmr_pkg::REG_RECT_HEIGHT: cfg.rect_height = value[12:0];
                rmr_pkg::REG_FRAME_ROWS:  cfg.frame_rows  = value[12:0];
                rmr_pkg::REG_FLIP_ROWS:   cfg.flip_rows   = value[0];
                default: ;
            endcase
        endfunction

        // Floor of the quotient, saturated to one byte.
        function bit [7:0] clip_mean(bit [31:0] total, bit [31:0] area);
            bit [31:0] quot;
            quot = total / area;
            return (quot > 32'd255) ? 8'd255 : quot[7:0];
        endfunction

        function void take_pixel(bit [11:0] col, bit [11:0] row, bit [7:0] blue,
                                 bit [7:0] green, bit [7:0] red, bit last);
            int           left, top, width, height, rows, k;
            bit           col_ok, row_ok;
            bit [31:0]    area;
            t_mean_result res;
            left   = cfg.rect_left;
            top    = cfg.rect_top;
            width  = cfg.rect_width;
            height = cfg.rect_height;
            rows   = cfg.frame_rows;
            col_ok = int'(col) >= left && int'(col) < left + width;
            // A flipped frame stores display row top+k at buffer row rows-1-top-k.
            if (cfg.flip_rows) begin
                k      = rows - 1 - top - int'(row);
                row_ok = k >= 0 && k < height;
            end else begin
                row_ok = int'(row) >= top && int'(row) < top + height;
            end
            if (col_ok && row_ok) begin
                red_sum   += red;
                green_sum += green;
                blue_sum  += blue;
            end
            if (last) begin
                area = width * height;
                if (area == 0) begin
                    res = '0;
                    res.empty = 1'b1;
                end else begin
                    res.red   = clip_mean(red_sum, area);
                    res.green = clip_mean(green_sum, area);
                    res.blue  = clip_mean(blue_sum, area);
                    res.empty = 1'b0;
                end
                pending_means.push_back(res);
                red_sum   = '0;
                green_sum = '0;
                blue_sum  = '0;
            end
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
            end
        endfunction

        function void compare_mean(logic [23:0] data, logic user);
            t_mean_result want;
            if (pending_means.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result, tdata %h tuser %b",
                             $realtime, data, user);
                return;
            end
            want = pending_means.pop_front();
            check_field("mean_red", want.red, data[7:0]);
            check_field("mean_green", want.green, data[15:8]);
            check_field("mean_blue", want.blue, data[23:16]);
            check_field("empty_region", {7'd0, want.empty}, {7'd0, user});
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [rmr_pkg::ADDR_W-1:0] paddr;
    logic [rmr_pkg::DATA_W-1:0] pwdata;
    logic [rmr_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    // tdata: pixel_col[11:0], pixel_row[23:12], blue_byte[31:24],
    //        green_byte[39:32], red_byte[47:40]
    logic [47:0]                s_axis_tdata;
    // tlast: frame_end
    logic                       s_axis_tlast;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    // tdata: mean_red[7:0], mean_green[15:8], mean_blue[23:16]
    logic [23:0]                m_axis_tdata;
    // tuser: empty_region
    logic                       m_axis_tuser;

    mean_tracker means = new();
    bit          calm;
    int          random_items;

    region_mean_rgb u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a 12 ns period.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The result side stalls at random except during the calm stretch.
    always @(negedge i_clk) begin
        m_axis_tready = calm ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Every result transfer is checked against the oldest expected mean.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            means.compare_mean(m_axis_tdata, m_axis_tuser);
    end

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(rmr_pkg::t_reg_idx idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        means.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Hold the pixel stream until every expected mean has arrived and the
    // block has had time to finish any frame in flight.
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (means.pending_means.size() != 0) @(negedge i_clk);
        repeat (RESULT_LATENCY) @(negedge i_clk);
    endtask

    task automatic set_rect(int left, int top, int width, int height, int rows,
                            bit flip);
        wait_drained();
        write_reg(rmr_pkg::REG_RECT_LEFT, left);
        write_reg(rmr_pkg::REG_RECT_TOP, top);
        write_reg(rmr_pkg::REG_RECT_WIDTH, width);
        write_reg(rmr_pkg::REG_RECT_HEIGHT, height);
        write_reg(rmr_pkg::REG_FRAME_ROWS, rows);
        write_reg(rmr_pkg::REG_FLIP_ROWS, flip);
    endtask

    // One pixel transfer, with a random gap in front of it outside the calm stretch.
    task automatic send_pixel(int col, int row, int blue, int green, int red, bit last);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {red[7:0], green[7:0], blue[7:0], row[11:0], col[11:0]};
        s_axis_tlast  = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        means.take_pixel(col[11:0], row[11:0], blue[7:0], green[7:0], red[7:0], last);
        @(negedge i_clk);
    endtask

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
    endfunction

    // Pick a rectangle: mostly small and near the origin, sometimes extreme.
    task automatic randomize_rect();
        int left, top, width, height, rows;
        int pick;
        pick   = $urandom_range(99);
        left   = (pick < 5) ? 4095 : ((pick < 12) ? $urandom_range(4095) : $urandom_range(12));
        pick   = $urandom_range(99);
        top    = (pick < 5) ? 4095 : ((pick < 12) ? $urandom_range(4095) : $urandom_range(12));
        pick   = $urandom_range(99);
        width  = (pick < 8) ? 0 : ((pick < 14) ? 4096 :
                 ((pick < 18) ? $urandom_range(4096) : $urandom_range(1, 6)));
        pick   = $urandom_range(99);
        height = (pick < 8) ? 0 : ((pick < 14) ? 4096 :
                 ((pick < 18) ? $urandom_range(4096) : $urandom_range(1, 6)));
        pick   = $urandom_range(99);
        rows   = (pick < 10) ? 4096 : ((pick < 15) ? 1 :
                 ((pick < 20) ? $urandom_range(1, 4096) : $urandom_range(1, 20)));
        set_rect(left, top, width, height, rows, 1'($urandom_range(1)));
    endtask

    // A frame of pixels, most of them near the rectangle's edges.
    task automatic send_random_frame(int len);
        int left, top, width, height, rows;
        int span_c, span_r, col_lo, row_lo, col, row;
        left   = means.cfg.rect_left;
        top    = means.cfg.rect_top;
        width  = means.cfg.rect_width;
        height = means.cfg.rect_height;
        rows   = means.cfg.frame_rows;
        span_c = (width > 8) ? 8 : width;
        span_r = (height > 8) ? 8 : height;
        col_lo = left - 2;
        row_lo = (means.cfg.flip_rows ? rows - top - span_r : top) - 2;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 80) begin
                col = clamp_coord(col_lo + $urandom_range(span_c + 4));
                row = clamp_coord(row_lo + $urandom_range(span_r + 4));
            end else begin
                col = $urandom_range(4095);
                row = $urandom_range(4095);
            end
            send_pixel(col, row, $urandom_range(255), $urandom_range(255),
                       $urandom_range(255), i == len - 1);
            random_items++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        calm          = 1'b0;
        random_items  = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings have a zero-sized rectangle, so the frame is empty.
        send_pixel(0, 0, 255, 255, 255, 1'b1);

        // Single-pixel area hit twice at full value: the quotient saturates.
        set_rect(0, 0, 1, 1, 4096, 1'b0);
        send_pixel(0, 0, 255, 255, 255, 1'b0);
        send_pixel(0, 0, 255, 255, 255, 1'b0);
        send_pixel(1, 0, 7, 7, 7, 1'b1);
        send_pixel(0, 0, 0, 0, 0, 1'b1);

        // Largest rectangle starting at the far corner runs past the frame edge.
        set_rect(4095, 4095, 4096, 4096, 4096, 1'b0);
        send_pixel(4095, 4095, 255, 0, 128, 1'b0);
        send_pixel(4094, 4095, 255, 255, 255, 1'b0);
        send_pixel(4095, 4095, 1, 2, 3, 1'b1);

        // Flipped rows: display rows 1 and 2 of an 8-row frame are rows 6 and 5.
        set_rect(3, 1, 2, 2, 8, 1'b1);
        send_pixel(3, 6, 40, 80, 120, 1'b0);
        send_pixel(4, 5, 44, 88, 200, 1'b0);
        send_pixel(3, 1, 255, 255, 255, 1'b0);
        send_pixel(5, 6, 255, 255, 255, 1'b0);
        send_pixel(4, 7, 255, 255, 255, 1'b0);
        send_pixel(3, 5, 0, 255, 8, 1'b1);

        // Flipped with the top row beyond the frame: no row matches.
        set_rect(0, 10, 4, 3, 4, 1'b1);
        send_pixel(0, 0, 200, 200, 200, 1'b0);
        send_pixel(1, 3, 200, 200, 200, 1'b1);

        // Zero height with nonzero width is still empty.
        set_rect(0, 0, 5, 0, 4096, 1'b0);
        send_pixel(0, 0, 9, 9, 9, 1'b1);

        // Full-width single row of a one-row flipped frame.
        set_rect(0, 0, 4096, 1, 1, 1'b1);
        send_pixel(4095, 0, 255, 255, 255, 1'b0);
        send_pixel(0, 0, 1, 1, 1, 1'b1);

        // Random phases, each with new settings and a few frames.
        while (random_items < RANDOM_ITEMS) begin
            calm = random_items >= 500 && random_items < 800;
            randomize_rect();
            repeat ($urandom_range(1, 4))
                send_random_frame(($urandom_range(9) == 0) ? $urandom_range(30, 60)
                                                           : $urandom_range(1, 30));
        end

        wait_drained();
        if (means.mismatches == 0 && means.pending_means.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/rmr_pkg.sv
rtl/core/rmr_regs.sv
rtl/core/rmr_ctrl.sv
rtl/core/rmr_datapath.sv
rtl/core/region_mean_rgb.sv
tb/sv/tb_region_mean_rgb.sv
